/* hw/rtl/hhbm_pkg.sv */
// ----------------------------------------------------------------------------
// hhbm_pkg
// Types and constants shared by the host heartbeat acknowledge monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package hhbm_pkg;

  localparam logic [0:0]  CMD_TICK = 1'b0;
  localparam logic [0:0]  CMD_LINK = 1'b1;

  localparam logic [63:0] SCRATCH_HOST_UP    = 64'd1;
  localparam logic [63:0] SCRATCH_HOST_ACK   = 64'd2;
  localparam logic [63:0] SCRATCH_HOST_RMMOD = 64'd3;

  localparam logic [5:0]  BIT_HEARTBEAT  = 6'd1;
  localparam logic [5:0]  LINK_DOWN_BASE = 6'd2;
  localparam logic [5:0]  LINK_UP_BASE   = 6'd18;
  localparam logic [15:0] MAX_PORT       = 16'd15;

  localparam logic [1:0]  STATUS_OK           = 2'd0;
  localparam logic [1:0]  STATUS_READ_FAILED  = 2'd1;
  localparam logic [1:0]  STATUS_ACK_TIMEOUT  = 2'd2;
  localparam logic [1:0]  STATUS_INVALID_PORT = 2'd3;

  localparam logic [1:0]  REG_HEARTBEAT_INTERVAL = 2'd0;
  localparam logic [1:0]  REG_HOST_POLL_INTERVAL = 2'd1;
  localparam logic [1:0]  REG_ACK_MISS_LIMIT     = 2'd2;

  localparam logic [15:0] HEARTBEAT_INTERVAL_RESET = 16'd5000;
  localparam logic [15:0] HOST_POLL_INTERVAL_RESET = 16'd100;
  localparam logic [3:0]  ACK_MISS_LIMIT_RESET     = 4'd5;

  typedef enum logic {
    PHASE_WAIT_UP  = 1'b0,
    PHASE_WAIT_ACK = 1'b1
  } phase_t;

  typedef struct packed {
    logic [0:0]  command;
    logic [63:0] scratch_value;
    logic        read_failed;
    logic [15:0] port_number;
    logic        link_up;
  } in_item_t;

  typedef struct packed {
    logic        send_trigger;
    logic [5:0]  trigger_bit;
    logic        clear_scratch;
    logic        cleanup_request;
    logic [15:0] next_alarm_ms;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [15:0] heartbeat_interval_ms;
    logic [15:0] host_poll_interval_ms;
    logic [3:0]  ack_miss_limit;
  } cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/hhbm_in_reg.sv */
// ----------------------------------------------------------------------------
// hhbm_in_reg
// Input register stage: captures one word and holds it until it advances.
// ----------------------------------------------------------------------------
`default_nettype none

module hhbm_in_reg
  import hhbm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  input  wire logic     advance,
  output logic          stage_valid,
  output in_item_t      stage_item
);

  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_item;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hhbm_step.sv */
// ----------------------------------------------------------------------------
// hhbm_step
// Heartbeat state and per-word decision logic for ticks and link events.
// ----------------------------------------------------------------------------
`default_nettype none

module hhbm_step
  import hhbm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     fire,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output out_item_t     result
);

  phase_t     phase;
  phase_t     phase_next;
  logic       heartbeat_pending;
  logic       heartbeat_pending_next;
  logic [3:0] missed_acks;
  logic [3:0] missed_acks_next;
  logic [3:0] missed_inc;

  assign missed_inc = missed_acks + 4'd1;

  always_comb begin
    result                 = '0;
    phase_next             = phase;
    heartbeat_pending_next = heartbeat_pending;
    missed_acks_next       = missed_acks;
    priority if (item.command == CMD_LINK) begin
      if (item.port_number > MAX_PORT) begin
        result.status = STATUS_INVALID_PORT;
      end else begin
        result.send_trigger = 1'b1;
        result.trigger_bit  = {2'b00, item.port_number[3:0]} +
                              (item.link_up ? LINK_UP_BASE : LINK_DOWN_BASE);
      end
    end else if (phase == PHASE_WAIT_UP) begin
      result.next_alarm_ms = cfg.host_poll_interval_ms;
      if (item.read_failed) begin
        result.status = STATUS_READ_FAILED;
      end else if (item.scratch_value == SCRATCH_HOST_UP) begin
        result.clear_scratch = 1'b1;
        result.send_trigger  = 1'b1;
        result.trigger_bit   = BIT_HEARTBEAT;
        phase_next           = PHASE_WAIT_ACK;
      end
    end else if (!heartbeat_pending) begin
      result.send_trigger    = 1'b1;
      result.trigger_bit     = BIT_HEARTBEAT;
      result.next_alarm_ms   = cfg.heartbeat_interval_ms;
      heartbeat_pending_next = 1'b1;
    end else if (item.read_failed) begin
      result.status        = STATUS_READ_FAILED;
      result.next_alarm_ms = cfg.heartbeat_interval_ms;
    end else if (item.scratch_value == SCRATCH_HOST_ACK) begin
      result.clear_scratch   = 1'b1;
      result.next_alarm_ms   = cfg.heartbeat_interval_ms;
      missed_acks_next       = 4'd0;
      heartbeat_pending_next = 1'b0;
    end else if (item.scratch_value == SCRATCH_HOST_RMMOD) begin
      result.cleanup_request = 1'b1;
      result.next_alarm_ms   = cfg.heartbeat_interval_ms;
      phase_next             = PHASE_WAIT_UP;
      missed_acks_next       = 4'd0;
    end else if (missed_inc >= cfg.ack_miss_limit) begin
      result.cleanup_request = 1'b1;
      result.status          = STATUS_ACK_TIMEOUT;
      result.next_alarm_ms   = cfg.host_poll_interval_ms;
      phase_next             = PHASE_WAIT_UP;
      missed_acks_next       = 4'd0;
    end else begin
      result.next_alarm_ms = cfg.heartbeat_interval_ms;
      missed_acks_next     = missed_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PHASE_WAIT_UP;
      heartbeat_pending <= 1'b0;
      missed_acks       <= 4'd0;
    end else if (fire) begin
      phase             <= phase_next;
      heartbeat_pending <= heartbeat_pending_next;
      missed_acks       <= missed_acks_next;
    end
  end

  a_idle_no_misses: assert property (@(posedge clk) disable iff (rst)
    phase == PHASE_WAIT_UP |-> missed_acks == 4'd0)
    else $error("missed acknowledges counted while waiting for host up");

  a_cleanup_returns: assert property (@(posedge clk) disable iff (rst)
    fire && result.cleanup_request |=> phase == PHASE_WAIT_UP)
    else $error("cleanup did not return to waiting for host up");

  a_no_trigger_no_bit: assert property (@(posedge clk) disable iff (rst)
    !result.send_trigger |-> result.trigger_bit == 6'd0)
    else $error("trigger bit set without a trigger");

endmodule

`default_nettype wire

/* hw/rtl/hhbm_out_reg.sv */
// ----------------------------------------------------------------------------
// hhbm_out_reg
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hhbm_out_reg
  import hhbm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  input  wire out_item_t result,
  output logic           can_load,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= result;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/host_heartbeat_ack_monitor.sv */
// ----------------------------------------------------------------------------
// host_heartbeat_ack_monitor
// Host heartbeat and link-event monitor with register-stage handshakes.
// ----------------------------------------------------------------------------
// Each input word (alarm tick or link event) yields one result word. A word
// passes an input register, is decided combinationally against the heartbeat
// state and lands in a result register; one word is taken every cycle while
// the result register is not held by the consumer. The decision stage makes a
// single state update per word. Configuration writes take effect at once; the
// user must make them while idle, which the block itself does not enforce.
`default_nettype none

module host_heartbeat_ack_monitor
  import hhbm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_item,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t      cfg;
  logic      stage_valid;
  in_item_t  stage_item;
  logic      can_load;
  logic      advance;
  out_item_t result;

  assign advance = stage_valid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heartbeat_interval_ms <= HEARTBEAT_INTERVAL_RESET;
      cfg.host_poll_interval_ms <= HOST_POLL_INTERVAL_RESET;
      cfg.ack_miss_limit        <= ACK_MISS_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEARTBEAT_INTERVAL: cfg.heartbeat_interval_ms <= cfg_data;
        REG_HOST_POLL_INTERVAL: cfg.host_poll_interval_ms <= cfg_data;
        REG_ACK_MISS_LIMIT:     cfg.ack_miss_limit        <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  hhbm_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  hhbm_step u_step (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (stage_item),
    .cfg    (cfg),
    .result (result)
  );

  hhbm_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result    (result),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !out_valid |=> out_valid)
    else $error("decided word did not reach the result register");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    stage_valid && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while both stages are blocked");

  a_poll_delay: assert property (@(posedge clk) disable iff (rst)
    advance && result.status == STATUS_ACK_TIMEOUT
      |-> result.next_alarm_ms == cfg.host_poll_interval_ms)
    else $error("timeout without the host poll delay");

endmodule

`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the host heartbeat acknowledge monitor: a
// queue-fed driver offers alarm ticks and link events, a shadow of the
// heartbeat state predicts each result word, and a monitor checks the
// results field by field across several interval and miss-limit settings.
// ----------------------------------------------------------------------------
module testbench;
  import hhbm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int WORDS_PER_SETTING = 100;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_HEARTBEAT_INTERVAL;
  logic [15:0] cfg_data = '0;

  host_heartbeat_ack_monitor uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_item_t  pending_words[$];
  out_item_t expected_results[$];

  // heartbeat state shadow
  cfg_t        shadow_cfg;
  phase_t      shadow_phase;
  logic        shadow_hb_sent;
  logic [3:0]  shadow_misses;

  int words_queued = 0;
  int words_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int settings_used = 1;
  int timeouts_seen = 0;
  int removals_seen = 0;
  int links_seen = 0;
  int acks_seen = 0;

  logic in_taken = 1'b0;
  logic held_once = 1'b0;
  int   hold_left = 0;
  wire  calm = (words_sent >= 300) && (words_sent < 420);

  function automatic out_item_t decide_word(input in_item_t w);
    out_item_t r;
    r = '0;
    if (w.command == CMD_LINK) begin
      links_seen++;
      if (w.port_number > MAX_PORT) begin
        r.status = STATUS_INVALID_PORT;
      end else begin
        r.send_trigger = 1'b1;
        r.trigger_bit = w.port_number[5:0] + (w.link_up ? LINK_UP_BASE : LINK_DOWN_BASE);
      end
    end else if (shadow_phase == PHASE_WAIT_UP) begin
      r.next_alarm_ms = shadow_cfg.host_poll_interval_ms;
      if (w.read_failed) begin
        r.status = STATUS_READ_FAILED;
      end else if (w.scratch_value == SCRATCH_HOST_UP) begin
        r.clear_scratch = 1'b1;
        r.send_trigger = 1'b1;
        r.trigger_bit = BIT_HEARTBEAT;
        shadow_phase = PHASE_WAIT_ACK;
      end
    end else if (!shadow_hb_sent) begin
      r.send_trigger = 1'b1;
      r.trigger_bit = BIT_HEARTBEAT;
      r.next_alarm_ms = shadow_cfg.heartbeat_interval_ms;
      shadow_hb_sent = 1'b1;
    end else if (w.read_failed) begin
      r.status = STATUS_READ_FAILED;
      r.next_alarm_ms = shadow_cfg.heartbeat_interval_ms;
    end else if (w.scratch_value == SCRATCH_HOST_ACK) begin
      acks_seen++;
      r.clear_scratch = 1'b1;
      r.next_alarm_ms = shadow_cfg.heartbeat_interval_ms;
      shadow_misses = '0;
      shadow_hb_sent = 1'b0;
    end else if (w.scratch_value == SCRATCH_HOST_RMMOD) begin
      removals_seen++;
      r.cleanup_request = 1'b1;
      r.next_alarm_ms = shadow_cfg.heartbeat_interval_ms;
      shadow_phase = PHASE_WAIT_UP;
      shadow_misses = '0;
    end else begin
      shadow_misses = shadow_misses + 4'd1;
      if (shadow_misses >= shadow_cfg.ack_miss_limit) begin
        timeouts_seen++;
        r.cleanup_request = 1'b1;
        r.status = STATUS_ACK_TIMEOUT;
        r.next_alarm_ms = shadow_cfg.host_poll_interval_ms;
        shadow_phase = PHASE_WAIT_UP;
        shadow_misses = '0;
      end else begin
        r.next_alarm_ms = shadow_cfg.heartbeat_interval_ms;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 50)
      $display("mismatch at result %0d: %s got %0h, want %0h",
               results_checked, what, got, want);
    mismatches++;
  endtask

  // input side: predict on acceptance; output side: check against oldest word
  always @(posedge clk) begin
    out_item_t want;
    in_taken <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      expected_results.push_back(decide_word(in_item));
      words_sent++;
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word", 64'(out_item), '0);
      end else begin
        want = expected_results.pop_front();
        if (out_item.send_trigger !== want.send_trigger)
          report_mismatch("send_trigger", 64'(out_item.send_trigger),
                          64'(want.send_trigger));
        if (out_item.trigger_bit !== want.trigger_bit)
          report_mismatch("trigger_bit", 64'(out_item.trigger_bit),
                          64'(want.trigger_bit));
        if (out_item.clear_scratch !== want.clear_scratch)
          report_mismatch("clear_scratch", 64'(out_item.clear_scratch),
                          64'(want.clear_scratch));
        if (out_item.cleanup_request !== want.cleanup_request)
          report_mismatch("cleanup_request", 64'(out_item.cleanup_request),
                          64'(want.cleanup_request));
        if (out_item.next_alarm_ms !== want.next_alarm_ms)
          report_mismatch("next_alarm_ms", 64'(out_item.next_alarm_ms),
                          64'(want.next_alarm_ms));
        if (out_item.status !== want.status)
          report_mismatch("status", 64'(out_item.status), 64'(want.status));
      end
      results_checked++;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_words.size() != 0 && (calm || $urandom_range(0, 99) >= 26)) begin
        in_item <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!held_once && words_sent >= 150) begin
      held_once <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || $urandom_range(0, 99) >= 26;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  task automatic queue_word(input in_item_t w);
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic queue_tick(input logic [63:0] scratch, input logic failed);
    in_item_t w;
    w.command = CMD_TICK;
    w.scratch_value = scratch;
    w.read_failed = failed;
    w.port_number = 16'($urandom);
    w.link_up = 1'($urandom);
    queue_word(w);
  endtask

  task automatic queue_link(input logic [15:0] port, input logic up);
    in_item_t w;
    w.command = CMD_LINK;
    w.scratch_value = {$urandom, $urandom};
    w.read_failed = 1'($urandom);
    w.port_number = port;
    w.link_up = up;
    queue_word(w);
  endtask

  function automatic in_item_t random_word();
    in_item_t w;
    w.command = ($urandom_range(0, 99) < 15) ? CMD_LINK : CMD_TICK;
    w.read_failed = $urandom_range(0, 99) < 8;
    case ($urandom_range(0, 9))
      0, 1:       w.scratch_value = SCRATCH_HOST_UP;
      2, 3, 4, 5: w.scratch_value = SCRATCH_HOST_ACK;
      6:          w.scratch_value = SCRATCH_HOST_RMMOD;
      7:          w.scratch_value = '0;
      8:          w.scratch_value = {$urandom, $urandom};
      default:    w.scratch_value = 64'($urandom_range(0, 7));
    endcase
    w.port_number = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
    w.link_up = 1'($urandom);
    return w;
  endfunction

  task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_HEARTBEAT_INTERVAL: shadow_cfg.heartbeat_interval_ms = value;
      REG_HOST_POLL_INTERVAL: shadow_cfg.host_poll_interval_ms = value;
      REG_ACK_MISS_LIMIT:     shadow_cfg.ack_miss_limit = value[3:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] hb, input logic [15:0] poll,
                                input logic [3:0] limit);
    write_register(REG_HEARTBEAT_INTERVAL, hb);
    write_register(REG_HOST_POLL_INTERVAL, poll);
    write_register(REG_ACK_MISS_LIMIT, {12'd0, limit});
    settings_used++;
  endtask

  task automatic wait_drained();
    while (results_checked != words_queued) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    shadow_cfg.heartbeat_interval_ms = HEARTBEAT_INTERVAL_RESET;
    shadow_cfg.host_poll_interval_ms = HOST_POLL_INTERVAL_RESET;
    shadow_cfg.ack_miss_limit = ACK_MISS_LIMIT_RESET;
    shadow_phase = PHASE_WAIT_UP;
    shadow_hb_sent = 1'b0;
    shadow_misses = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // link events at the port extremes, valid and invalid
    queue_link(16'd0, 1'b0);
    queue_link(16'd15, 1'b1);
    queue_link(16'd16, 1'b0);
    queue_link(16'hFFFF, 1'b1);
    queue_link(16'd7, 1'b1);
    // waiting for host up: failed read, idle values, then host up
    queue_tick(SCRATCH_HOST_UP, 1'b1);
    queue_tick('0, 1'b0);
    queue_tick('1, 1'b0);
    queue_tick(SCRATCH_HOST_UP, 1'b0);
    // heartbeat tick ignores the read flag, then failed read, ack, removal
    queue_tick('1, 1'b1);
    queue_tick(SCRATCH_HOST_ACK, 1'b1);
    queue_tick(SCRATCH_HOST_ACK, 1'b0);
    queue_tick('0, 1'b0);
    queue_tick(SCRATCH_HOST_RMMOD, 1'b0);
    // back up, then miss acknowledges until timeout
    queue_tick(SCRATCH_HOST_UP, 1'b0);
    queue_tick('0, 1'b0);
    repeat (4) queue_tick({$urandom, $urandom} | 64'h10, 1'b0);
    queue_tick(SCRATCH_HOST_UP + 64'd8, 1'b0);
    // heartbeat still marked sent: next tick after host up checks at once
    queue_tick(SCRATCH_HOST_UP, 1'b0);
    queue_tick(SCRATCH_HOST_ACK, 1'b0);
    queue_tick('0, 1'b0);
    wait_drained();

    for (int s = 0; s < 6; s++) begin
      case (s)
        0: apply_settings(16'd1, 16'd1, 4'd1);
        1: apply_settings(16'hFFFF, 16'hFFFF, 4'd15);
        2: apply_settings(16'd0, 16'd0, 4'd0);
        3: apply_settings(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                          4'($urandom_range(1, 15)));
        4: apply_settings(16'($urandom), 16'($urandom), 4'($urandom_range(1, 3)));
        default: apply_settings(HEARTBEAT_INTERVAL_RESET, HOST_POLL_INTERVAL_RESET,
                                ACK_MISS_LIMIT_RESET);
      endcase
      repeat (WORDS_PER_SETTING) queue_word(random_word());
      wait_drained();
    end

    while (expected_results.size() != 0) begin
      void'(expected_results.pop_front());
      report_mismatch("missing word", '0, '0);
    end
    $display("covered %0d words under %0d register settings, receiver held off once",
             words_sent, settings_used);
    $display("seen %0d link events, %0d acks, %0d removals, %0d ack timeouts",
             links_seen, acks_seen, removals_seen, timeouts_seen);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* host_heartbeat_ack_monitor.f */
hw/rtl/hhbm_pkg.sv
hw/rtl/hhbm_in_reg.sv
hw/rtl/hhbm_step.sv
hw/rtl/hhbm_out_reg.sv
hw/rtl/host_heartbeat_ack_monitor.sv
bench/testbench.sv
